/* rtl/cbus_dma_pkg.sv */
// Shared types, codes and constants for the console CPU bus with sprite DMA.
// No dependencies; imported by the top level.
package cbus_dma_pkg;

    localparam int RAM_BYTES_DEF = 2048;

    localparam logic [15:0] RAM_TOP     = 16'h1FFF;
    localparam logic [15:0] PPU_TOP     = 16'h3FFF;
    localparam logic [15:0] PPU_MASK    = 16'h0007;
    localparam logic [15:0] APU_BASE    = 16'h4000;
    localparam logic [15:0] APU_LAST    = 16'h4013;
    localparam logic [15:0] APU_STATUS  = 16'h4015;
    localparam logic [15:0] APU_FRAME   = 16'h4017;
    localparam logic [15:0] DMA_REG     = 16'h4014;
    localparam logic [15:0] PAD_REG     = 16'h4016;
    localparam logic [15:0] CART_BASE   = 16'h8000;

    localparam logic [2:0] PHASE_EVEN = 3'd0;
    localparam logic [2:0] PHASE_ODD  = 3'd3;
    localparam logic [2:0] PHASE_LAST = 3'd5;

    localparam logic [3:0] PAD_BITS   = 4'd8;
    localparam logic [7:0] DMA_LAST   = 8'hFF;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_TICK  = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        TGT_NONE     = 3'd0,
        TGT_RAM      = 3'd1,
        TGT_PPU      = 3'd2,
        TGT_APU      = 3'd3,
        TGT_DMA      = 3'd4,
        TGT_PAD      = 3'd5,
        TGT_CART     = 3'd6,
        TGT_UNMAPPED = 3'd7
    } target_t;

    // One result beat as it travels through the pipeline.
    typedef struct packed {
        target_t     target;
        logic [15:0] local_addr;
        logic        is_write;
        logic [7:0]  write_data;
        logic [7:0]  read_data;
        logic        cpu_step;
        logic        dma_active;
        logic        oam_write;
        logic [7:0]  oam_index;
        logic [7:0]  oam_data;
        logic        raise_nmi;
    } result_t;

    // Address decode in priority order.
    function automatic target_t decode_target(input logic [15:0] a, input logic cart);
        target_t t;
        if (a <= RAM_TOP) begin
            t = TGT_RAM;
        end else if (a <= PPU_TOP) begin
            t = TGT_PPU;
        end else if ((a >= APU_BASE && a <= APU_LAST) || a == APU_STATUS
                     || a == APU_FRAME) begin
            t = TGT_APU;
        end else if (a == DMA_REG) begin
            t = TGT_DMA;
        end else if (a == PAD_REG) begin
            t = TGT_PAD;
        end else if (cart && a >= CART_BASE) begin
            t = TGT_CART;
        end else begin
            t = TGT_UNMAPPED;
        end
        return t;
    endfunction

endpackage

/* rtl/console_cpu_bus_with_oam_dma_top.sv */
// Top level of the console CPU bus with sprite-memory DMA: decode, work RAM,
// controller shift register, DMA sequencer and output register. Uses cbus_dma_pkg.

// The block takes one beat per clock on the input channel while in_stall is
// low; a beat may be a CPU read, a CPU write or one PPU clock tick, and the
// block returns exactly one result beat for each, in order. Throughput is one
// beat per cycle with no bubbles while out_stall is low. A beat is registered
// in the memory stage at the edge that accepts it, together with the
// synchronous read of the work RAM, and moves on to the output register, where
// its result is offered, once that register is empty or being taken. The work
// RAM is a single memory of RAM_BYTES bytes with one write and one read
// port; a write is committed at the edge where its beat is accepted, so a
// read in the following beat already sees it. The RAM is not cleared after
// reset, and reading a byte that was never written returns whatever the
// memory holds. The tick phase, the DMA sequencer and the controller shift
// register are updated at acceptance. The DMA byte is captured as the DMA
// read leaves the memory stage, which always happens before the matching
// sprite write reaches that stage, so there is no interlock. The result
// pipeline still accepts a beat into an empty memory stage while a finished
// result waits on a stalled output; the input is stalled only when both the
// memory stage and the output register are full. The cartridge-present
// register cart_reg is written through the cfg channel, which is always
// ready, and must only be written while the block is idle.
module console_cpu_bus_with_oam_dma_top #(
    parameter int RAM_BYTES = cbus_dma_pkg::RAM_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  op,
    input  logic [15:0] address,
    input  logic [7:0]  data,
    input  logic [7:0]  ext_data,
    input  logic [7:0]  buttons,
    input  logic        nmi_request,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  target,
    output logic [15:0] local_addr,
    output logic        is_write,
    output logic [7:0]  write_data,
    output logic [7:0]  read_data,
    output logic        cpu_step,
    output logic        dma_active,
    output logic        oam_write,
    output logic [7:0]  oam_index,
    output logic [7:0]  oam_data,
    output logic        raise_nmi
);
    import cbus_dma_pkg::*;

    localparam int AW = $clog2(RAM_BYTES);

    // Configuration.
    logic cart_reg;

    // Control state.
    logic [2:0] tick_phase_reg, tick_phase_next;
    logic       dma_busy_reg, dma_busy_next;
    logic       dma_armed_reg, dma_armed_next;
    logic [7:0] dma_page_reg, dma_page_next;
    logic [7:0] dma_index_reg, dma_index_next;
    logic [7:0] dma_byte_reg, dma_byte_next;
    logic [7:0] pad_shift_reg, pad_shift_next;
    logic [3:0] pad_reads_reg, pad_reads_next;

    // Pipeline.
    logic    s1_valid_reg, s1_valid_next;
    result_t s1_res_reg;
    logic    s1_use_ram_reg;
    logic    s1_dma_rd_reg;
    logic    out_valid_reg, out_valid_next;
    result_t out_res_reg;
    result_t s1_final;

    // Work RAM.
    logic [7:0] work_ram [RAM_BYTES];
    logic [7:0] ram_q_reg;
    logic       ram_we;
    logic       ram_re;
    logic [AW-1:0] ram_waddr;
    logic [AW-1:0] ram_raddr;

    // Stage 0 combinational.
    op_t         op_c;
    logic        accept;
    logic        s1_adv;
    logic        slot;
    logic        odd_slot;
    logic        dma_rd;
    logic        do_read;
    logic [15:0] bus_addr;
    target_t     tgt;
    logic [AW-1:0] ram_off;
    logic [16:0] rem;
    logic [15:0] loc;
    logic [7:0]  pad_src;
    logic        use_ram;
    result_t     res0;

    assign cfg_ready = 1'b1;
    assign op_c      = op_t'(op);

    assign s1_adv   = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !s1_adv;
    assign accept   = in_valid && !in_stall;

    // CPU slots fall on phases 0 (even) and 3 (odd) of the six-tick cycle.
    assign slot     = (op_c == OP_TICK)
                      && (tick_phase_reg == PHASE_EVEN || tick_phase_reg == PHASE_ODD);
    assign odd_slot = (tick_phase_reg == PHASE_ODD);
    assign dma_rd   = slot && dma_busy_reg && dma_armed_reg && !odd_slot;
    assign do_read  = (op_c == OP_READ) || dma_rd;
    assign bus_addr = dma_rd ? {dma_page_reg, dma_index_reg} : address;
    assign tgt      = decode_target(bus_addr, cart_reg);

    // RAM offset: the mirrored range is at most 16 times the RAM size, so four
    // conditional subtractions leave the remainder.
    always_comb
    begin
        rem = {4'd0, bus_addr[12:0]};
        for (int k = 3; k >= 0; k--)
        begin
            if (rem >= 17'(RAM_BYTES << k))
            begin
                rem = rem - 17'(RAM_BYTES << k);
            end
        end
        ram_off = rem[AW-1:0];
    end

    always_comb
    begin
        unique case (tgt)
            TGT_RAM: loc = 16'(ram_off);
            TGT_PPU: loc = bus_addr & PPU_MASK;
            default: loc = bus_addr;
        endcase
    end

    assign pad_src = (pad_reads_reg == PAD_BITS) ? buttons : pad_shift_reg;
    assign use_ram = do_read && (tgt == TGT_RAM);

    assign ram_we    = accept && (op_c == OP_WRITE) && (tgt == TGT_RAM);
    assign ram_re    = accept && use_ram;
    assign ram_waddr = ram_off;
    assign ram_raddr = ram_off;

    // Next state of the control registers and the first half of the result.
    always_comb
    begin
        tick_phase_next = tick_phase_reg;
        dma_busy_next   = dma_busy_reg;
        dma_armed_next  = dma_armed_reg;
        dma_page_next   = dma_page_reg;
        dma_index_next  = dma_index_reg;
        pad_shift_next  = pad_shift_reg;
        pad_reads_next  = pad_reads_reg;
        res0            = '0;
        res0.target     = TGT_NONE;

        if (do_read)
        begin
            res0.target     = tgt;
            res0.local_addr = loc;
            case (tgt)
                TGT_DMA: res0.read_data = 8'd0;
                TGT_RAM: res0.read_data = 8'd0;
                TGT_PAD:
                begin
                    res0.read_data = {7'd0, pad_src[0]};
                    pad_shift_next = pad_src >> 1;
                    pad_reads_next = ((pad_reads_reg == PAD_BITS) ? 4'd0 : pad_reads_reg)
                                     + 4'd1;
                end
                default: res0.read_data = ext_data;
            endcase
        end

        if (op_c == OP_WRITE)
        begin
            res0.target     = tgt;
            res0.local_addr = loc;
            res0.is_write   = 1'b1;
            res0.write_data = data;
            if (tgt == TGT_DMA)
            begin
                dma_busy_next  = 1'b1;
                dma_page_next  = data;
                dma_index_next = 8'd0;
            end
        end

        if (op_c == OP_TICK)
        begin
            res0.raise_nmi  = nmi_request;
            tick_phase_next = (tick_phase_reg == PHASE_LAST) ? PHASE_EVEN
                                                             : tick_phase_reg + 3'd1;
            if (slot)
            begin
                if (!dma_busy_reg)
                begin
                    res0.cpu_step = 1'b1;
                end else if (!dma_armed_reg)
                begin
                    if (odd_slot)
                    begin
                        dma_armed_next = 1'b1;
                    end
                end else if (odd_slot)
                begin
                    // The byte itself is attached in the memory stage.
                    res0.oam_write = 1'b1;
                    res0.oam_index = dma_index_reg;
                    dma_index_next = dma_index_reg + 8'd1;
                    if (dma_index_reg == DMA_LAST)
                    begin
                        dma_busy_next  = 1'b0;
                        dma_armed_next = 1'b0;
                    end
                end
            end
        end

        res0.dma_active = dma_busy_next;
    end

    // Memory stage: merge the RAM read data and the DMA byte.
    always_comb
    begin
        s1_final = s1_res_reg;
        if (s1_use_ram_reg)
        begin
            s1_final.read_data = ram_q_reg;
        end
        if (s1_res_reg.oam_write)
        begin
            s1_final.oam_data = dma_byte_reg;
        end
    end

    assign dma_byte_next  = (s1_valid_reg && s1_adv && s1_dma_rd_reg) ? s1_final.read_data
                                                                       : dma_byte_reg;
    assign s1_valid_next  = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
    assign out_valid_next = s1_adv ? s1_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cart_reg       <= 1'b0;
            tick_phase_reg <= PHASE_EVEN;
            dma_busy_reg   <= 1'b0;
            dma_armed_reg  <= 1'b0;
            dma_page_reg   <= 8'd0;
            dma_index_reg  <= 8'd0;
            dma_byte_reg   <= 8'd0;
            pad_shift_reg  <= 8'd0;
            pad_reads_reg  <= PAD_BITS;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else
        begin
            if (cfg_valid && cfg_ready)
            begin
                cart_reg <= cfg_data;
            end
            if (accept)
            begin
                tick_phase_reg <= tick_phase_next;
                dma_busy_reg   <= dma_busy_next;
                dma_armed_reg  <= dma_armed_next;
                dma_page_reg   <= dma_page_next;
                dma_index_reg  <= dma_index_next;
                pad_shift_reg  <= pad_shift_next;
                pad_reads_reg  <= pad_reads_next;
            end
            dma_byte_reg  <= dma_byte_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_res_reg     <= res0;
            s1_use_ram_reg <= use_ram;
            s1_dma_rd_reg  <= dma_rd;
        end
        if (s1_adv && s1_valid_reg)
        begin
            out_res_reg <= s1_final;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ram_we)
        begin
            work_ram[ram_waddr] <= data;
        end
        if (ram_re)
        begin
            ram_q_reg <= work_ram[ram_raddr];
        end
    end

    assign out_valid  = out_valid_reg;
    assign target     = out_res_reg.target;
    assign local_addr = out_res_reg.local_addr;
    assign is_write   = out_res_reg.is_write;
    assign write_data = out_res_reg.write_data;
    assign read_data  = out_res_reg.read_data;
    assign cpu_step   = out_res_reg.cpu_step;
    assign dma_active = out_res_reg.dma_active;
    assign oam_write  = out_res_reg.oam_write;
    assign oam_index  = out_res_reg.oam_index;
    assign oam_data   = out_res_reg.oam_data;
    assign raise_nmi  = out_res_reg.raise_nmi;

`ifndef SYNTH
    // The sequencer only arms while a transfer is pending.
    a_armed_needs_busy: assert property (@(posedge clk) disable iff (!rst_n)
        dma_armed_reg |-> dma_busy_reg)
        else $error("DMA armed without a pending transfer");

    // The tick phase counts modulo six.
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        tick_phase_reg <= PHASE_LAST)
        else $error("tick phase out of range");

    // A sprite-memory write never coincides with a CPU step or a bus access.
    a_oam_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_res_reg.oam_write)
            |-> (!out_res_reg.cpu_step && out_res_reg.target == TGT_NONE))
        else $error("sprite write overlaps CPU step or bus access");

    // The input is held off only while the memory stage and the output register are both occupied.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg))
        else $error("input stalled with room in the pipeline");

    // A pipeline beat never vanishes while the output is held.
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> out_valid_reg)
        else $error("held result dropped");
`endif

endmodule
